FILE: rtl/trrg_pkg.sv
// Package: shared constants and controller-to-datapath command type for the TEA generator.
package trrg_pkg;

  localparam int ROUND_COUNT_DEF = 8;

  localparam int WORD_W     = 32;
  localparam int SEED_W     = 31;
  localparam int FRAC_W     = 64;
  localparam int KEY_COUNT  = 4;
  localparam int KEY_IDX_W  = 2;

  // integer square root on the triangle numbers: root fits in 16 bits
  localparam int ROOT_W     = 16;
  localparam int ROOT_IDX_W = 4;

  localparam logic [WORD_W-1:0] GOLDEN_DELTA = 32'h9E37_79B9;

  localparam logic [WORD_W-1:0] KEY0_RESET = 32'hC7D7_A8B4;
  localparam logic [WORD_W-1:0] KEY1_RESET = 32'h9ABF_B3B6;
  localparam logic [WORD_W-1:0] KEY2_RESET = 32'h73DC_1683;
  localparam logic [WORD_W-1:0] KEY3_RESET = 32'h17B7_BE43;

  localparam logic [WORD_W-1:0] MIX_A_RESET = 32'd123456789;
  localparam logic [WORD_W-1:0] MIX_B_RESET = 32'd987654321;

  localparam logic [KEY_IDX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] REG_KEY3 = 2'd3;

  localparam logic CMD_NEXT   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef struct packed {
    logic                  capture;    // latch seed, clear root search
    logic                  root_step;  // try one root bit
    logic [ROOT_IDX_W-1:0] root_bit;
    logic                  seed_load;  // map root to the word pair
    logic                  sum_init;   // running sum starts at one delta
    logic                  round_step; // one round on both words
    logic                  out_load;   // copy words into the result register
  } trrg_cmd_t;

endpackage

FILE: rtl/trrg_item_if.sv
// Interface: input item channel (command and seed).
interface trrg_item_if
  import trrg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [SEED_W-1:0] seed_value;

  modport source (output valid, command, seed_value, input ready);
  modport sink   (input valid, command, seed_value, output ready);
endinterface

FILE: rtl/trrg_result_if.sv
// Interface: result channel (64-bit fraction).
interface trrg_result_if
  import trrg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] random_fraction;

  modport source (output valid, random_fraction, input ready);
  modport sink   (input valid, random_fraction, output ready);
endinterface

FILE: rtl/trrg_cfg_if.sv
// Interface: key register write channel.
interface trrg_cfg_if
  import trrg_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KEY_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/trrg_dp.sv
// Datapath: key registers, mix words, root search and the TEA round unit.
module trrg_dp
  import trrg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  trrg_cmd_t            cmd,
  input  logic [SEED_W-1:0]    seed_value,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output logic [FRAC_W-1:0]    random_fraction
);

  logic [WORD_W-1:0] key [KEY_COUNT];
  logic [WORD_W-1:0] mix_a;
  logic [WORD_W-1:0] mix_b;
  logic [WORD_W-1:0] sum;
  logic [SEED_W-1:0] seed;
  logic [ROOT_W-1:0] root;
  logic [WORD_W-1:0] tri_root;
  logic [FRAC_W-1:0] result;

  logic [ROOT_W-1:0]   cand;
  logic [ROOT_W:0]     cand_x;
  logic [2*ROOT_W+1:0] cand_prod;
  logic [WORD_W-1:0]   cand_tri;
  logic                cand_fits;
  logic [WORD_W-1:0]   a_next;
  logic [WORD_W-1:0]   b_next;

  // candidate root and its triangle number cand*(cand+1)/2
  always_comb begin
    cand      = root | (ROOT_W'(1) << cmd.root_bit);
    cand_x    = {1'b0, cand};
    cand_prod = (2*ROOT_W+2)'(cand_x) * (2*ROOT_W+2)'(cand_x + (ROOT_W+1)'(1));
    cand_tri  = cand_prod[WORD_W:1];
    cand_fits = cand_tri <= {1'b0, seed};
  end

  // one round: b updates from the new a
  always_comb begin
    a_next = mix_a + (mix_b << 4) + (key[0] ^ mix_b) + (sum ^ (mix_b >> 5)) + key[1];
    b_next = mix_b + (a_next << 4) + (key[2] ^ a_next) + (sum ^ (a_next >> 5)) + key[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= KEY0_RESET;
      key[1] <= KEY1_RESET;
      key[2] <= KEY2_RESET;
      key[3] <= KEY3_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_a <= MIX_A_RESET;
      mix_b <= MIX_B_RESET;
    end else if (cmd.seed_load) begin
      // b = seed - T(n), a = T(n+1) - 1 - seed = T(n) + n - seed
      mix_b <= {1'b0, seed} - tri_root;
      mix_a <= tri_root + {{(WORD_W-ROOT_W){1'b0}}, root} - {1'b0, seed};
    end else if (cmd.round_step) begin
      mix_a <= a_next;
      mix_b <= b_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seed     <= seed_value;
      root     <= '0;
      tri_root <= '0;
    end else if (cmd.root_step && cand_fits) begin
      root     <= cand;
      tri_root <= cand_tri;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      sum <= GOLDEN_DELTA;
    end else if (cmd.round_step) begin
      sum <= sum + GOLDEN_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= {mix_b, mix_a};
    end
  end

  assign random_fraction = result;

endmodule

FILE: rtl/trrg_ctrl.sv
// Controller: sequences root search, seed mapping, rounds and result hand-off.
module trrg_ctrl
  import trrg_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_command,
  output logic      item_ready,
  output logic      result_valid,
  input  logic      result_ready,
  output trrg_cmd_t cmd
);

  localparam int RCNT_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RCNT_W-1:0] ROUND_LAST = RCNT_W'(ROUND_COUNT - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROOT  = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic                  reseed;
  logic [ROOT_IDX_W-1:0] root_bit;
  logic [RCNT_W-1:0]     round_cnt;
  logic                  out_free;
  logic                  accept;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.root_bit   = root_bit;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.capture  = 1'b1;
          cmd.sum_init = 1'b1;
          state_next   = (item_command == CMD_RESEED) ? ST_ROOT : ST_ROUND;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (root_bit == '0) state_next = ST_SEED;
      end
      ST_SEED: begin
        cmd.seed_load = 1'b1;
        cmd.sum_init  = 1'b1;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (round_cnt == ROUND_LAST) begin
          // reseed discards its round set
          state_next = reseed ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      reseed       <= 1'b0;
      root_bit     <= '1;
      round_cnt    <= '0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) reseed <= (item_command == CMD_RESEED);
      if (accept) begin
        root_bit <= '1;
      end else if (cmd.root_step) begin
        root_bit <= root_bit - ROOT_IDX_W'(1);
      end
      if (cmd.round_step) begin
        round_cnt <= (round_cnt == ROUND_LAST) ? '0 : round_cnt + RCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || result_ready))
    else $error("result register overwritten while its beat waits");

  a_seed_then_round: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEED) |=> (state == ST_ROUND && round_cnt == '0))
    else $error("seed mapping not followed by a fresh round set");

  a_reseed_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && reseed) |=> (state == ST_ROUND || state == ST_IDLE))
    else $error("reseed round set headed for the result register");

  a_round_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && accept && item_command == CMD_NEXT) |=> (round_cnt == '0))
    else $error("round counter not at zero when a round set starts");
`endif

endmodule

FILE: rtl/tea_round_random_generator.sv
// Top level: TEA-round pseudo-random generator with key register port.
// A next beat runs ROUND_COUNT rounds, one round per cycle in a single round unit, and
// then the words are copied into the output register, and the result is then valid.
// The input takes its next beat as soon as the copy is made, even while the result
// still waits. A following next beat then holds before its copy until the output
// register is free. A reseed beat gives no result: a 16-step bit-serial integer square
// root (one step per cycle), a seed mapping step and a discarded round set. The next
// beat is taken once that round set ends.
// Key writes are accepted every cycle and should be made while the block is idle.
module tea_round_random_generator
  import trrg_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input logic          clk,
  input logic          rst,
  trrg_item_if.sink    item,
  trrg_result_if.source result,
  trrg_cfg_if.sink     cfg
);

  trrg_cmd_t cmd;

  assign cfg.ready = 1'b1;

  trrg_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  trrg_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .seed_value      (item.seed_value),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .random_fraction (result.random_fraction)
  );

endmodule

FILE: sim/tea_round_random_generator_test.sv
`timescale 1ns / 1ps
// Testbench: TEA-round random generator, directed script plus random next/reseed traffic.
module tea_round_random_generator_test;
  import trrg_pkg::*;

  localparam int ROUNDS         = ROUND_COUNT_DEF;
  localparam int SETTLE_CYCLES  = 2 * (17 + ROUNDS);
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 260;
  localparam int SCRIPT_LEN     = 18;

  typedef struct packed {
    logic              cmd;
    logic [SEED_W-1:0] seed;
  } script_row_t;

  // extremes, triangle-number edges of the seed map, alternating bits
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    {CMD_NEXT,   31'd0},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'd0},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'd1},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'd2},
    {CMD_RESEED, 31'd3},
    {CMD_NEXT,   31'h7FFF_FFFF},
    {CMD_RESEED, 31'h7FFF_FFFF},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'd2147450880},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'd2147450879},
    {CMD_NEXT,   31'd0},
    {CMD_RESEED, 31'h2AAA_AAAA},
    {CMD_RESEED, 31'h5555_5555},
    {CMD_NEXT,   31'h5555_5555}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  trrg_item_if   item_ch ();
  trrg_result_if res_ch ();
  trrg_cfg_if    cfg_ch ();

  tea_round_random_generator uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [WORD_W-1:0] key_word_q [KEY_COUNT];
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;
  logic [FRAC_W-1:0] pending_fractions [$];

  int   fail_count       = 0;
  int   quiet_cycles     = 0;
  bit   steady           = 1'b0;
  bit   hold_off_request = 1'b0;
  logic [FRAC_W-1:0] want_fraction;

  function automatic void spin_rounds();
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    s = '0;
    a = word_a;
    b = word_b;
    for (int r = 0; r < ROUNDS; r++) begin
      s = s + GOLDEN_DELTA;
      a = a + (b << 4) + (key_word_q[0] ^ b) + (s ^ (b >> 5)) + key_word_q[1];
      b = b + (a << 4) + (key_word_q[2] ^ a) + (s ^ (a >> 5)) + key_word_q[3];
    end
    word_a = a;
    word_b = b;
  endfunction

  // diagonal map: largest root with root(root+1)/2 <= seed, then one discarded round set
  function automatic void seed_pair(input logic [SEED_W-1:0] seed);
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] wide_seed;
    root = '0;
    wide_seed = {33'd0, seed};
    for (int k = 16; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if ((trial * (trial + 64'd1)) / 64'd2 <= wide_seed)
        root = trial;
    end
    word_b = 32'(wide_seed - (root * (root + 64'd1)) / 64'd2);
    word_a = 32'((root + 64'd1) * (root + 64'd2) / 64'd2 - 64'd1 - wide_seed);
    spin_rounds();
  endfunction

  function automatic void predict_item(input logic cmd, input logic [SEED_W-1:0] seed);
    if (cmd == CMD_RESEED) begin
      seed_pair(seed);
    end else begin
      spin_rounds();
      pending_fractions.push_back({word_b, word_a});
    end
  endfunction

  function automatic logic [SEED_W-1:0] pick_seed();
    logic [63:0] n;
    logic [63:0] s;
    case ($urandom_range(3))
      0: return SEED_W'($urandom());
      1: begin
        // first or last point on a random diagonal
        n = 64'($urandom_range(65535));
        s = n * (n + 64'd1) / 64'd2 + ($urandom_range(1) ? n : 64'd0);
        if (s > 64'h7FFF_FFFF)
          s = 64'h7FFF_FFFF;
        return SEED_W'(s);
      end
      2: return SEED_W'($urandom_range(1000));
      default: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
    endcase
  endfunction

  task automatic push_item(input logic cmd, input logic [SEED_W-1:0] seed);
    while (!steady && $urandom_range(99) < 34) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid      = 1'b1;
    item_ch.command    = cmd;
    item_ch.seed_value = seed;
    do @(posedge clk); while (!item_ch.ready);
    predict_item(cmd, seed);
    @(negedge clk);
  endtask

  task automatic write_key(input logic [KEY_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    while ($urandom_range(99) < 34)
      @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    key_word_q[idx] = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY3, k3);
    write_key(REG_KEY1, k1);
  endtask

  // block idle: every result in, then room for a trailing reseed round set
  task automatic settle();
    item_ch.valid = 1'b0;
    while (pending_fractions.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input int count, input int steady_from, input int steady_to,
                              input int hold_off_at);
    for (int i = 0; i < count; i++) begin
      steady = (i >= steady_from && i < steady_to);
      if (i == hold_off_at)
        hold_off_request = 1'b1;
      if ($urandom_range(99) < 75)
        push_item(CMD_NEXT, SEED_W'($urandom()));
      else
        push_item(CMD_RESEED, pick_seed());
    end
    steady = 1'b0;
  endtask

  // result side
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        res_ch.ready = 1'b0;
        repeat (HOLD_OFF_LEN) @(negedge clk);
      end
      res_ch.ready = steady || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_fractions.size() == 0) begin
          $display("%0t unexpected result beat: %h", $time, res_ch.random_fraction);
          fail_count++;
        end else begin
          want_fraction = pending_fractions.pop_front();
          if (res_ch.random_fraction !== want_fraction) begin
            $display("%0t random_fraction mismatch: expected %h actual %h",
                     $time, want_fraction, res_ch.random_fraction);
            fail_count++;
          end
        end
      end
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    item_ch.valid      = 1'b0;
    item_ch.command    = CMD_NEXT;
    item_ch.seed_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_KEY0;
    cfg_ch.data        = '0;
    key_word_q[REG_KEY0] = KEY0_RESET;
    key_word_q[REG_KEY1] = KEY1_RESET;
    key_word_q[REG_KEY2] = KEY2_RESET;
    key_word_q[REG_KEY3] = KEY3_RESET;
    word_a = MIX_A_RESET;
    word_b = MIX_B_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++)
      push_item(SCRIPT[i].cmd, SCRIPT[i].seed);
    settle();

    set_keys('0, '0, '0, '0);
    random_phase(PHASE_ITEMS, 0, 0, -1);
    settle();

    set_keys('1, '1, '1, '1);
    random_phase(PHASE_ITEMS, 0, 0, 50);
    settle();

    set_keys($urandom(), $urandom(), $urandom(), $urandom());
    random_phase(PHASE_ITEMS, 0, 150, -1);
    settle();

    set_keys('1, '0, $urandom(), $urandom());
    random_phase(PHASE_ITEMS, 0, 0, -1);
    settle();

    set_keys(KEY0_RESET, KEY1_RESET, KEY2_RESET, KEY3_RESET);
    random_phase(PHASE_ITEMS, 100, 180, -1);
    settle();

    if (pending_fractions.size() != 0)
      $display("%0t %0d expected results never arrived", $time, pending_fractions.size());
    if (fail_count == 0 && pending_fractions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
